// ===== rtl/core/cbms_pkg.sv =====
// Shared types, constants and helper functions of the calendar block-maxima store.
`timescale 1ns / 1ps
package cbms_pkg;

    localparam int DAY_W     = 14;
    localparam int LOC_W     = 8;
    localparam int VAL_W     = 32;
    localparam int BIN_OUT_W = 7;
    localparam int BIN_W     = 10;
    localparam int YEAR_W    = 6;
    localparam int DOY_W     = 10;
    localparam int MONTH_W   = 4;
    localparam int LIM_W     = 15;

    localparam logic [DAY_W-1:0] DAYS_PER_YEAR = 14'd365;
    localparam int               RECIP         = 2872;
    localparam int               RECIP_SHIFT   = 20;
    localparam logic [VAL_W-1:0] NEG_FLT_MAX   = 32'hFF7F_FFFF;

    localparam logic [1:0] MODE_ANNUAL   = 2'd0;
    localparam logic [1:0] MODE_MONTHLY  = 2'd1;
    localparam logic [1:0] MODE_SEASONAL = 2'd2;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_YEARS = 1'b1;

    localparam logic KIND_UPDATE = 1'b0;

    typedef struct packed {
        logic [1:0] aggregation_mode;
        logic [3:0] years_in_use;
    } t_cfg;

    typedef struct packed {
        logic             kind;
        logic [DAY_W-1:0] day;
        logic [LOC_W-1:0] location;
        logic [VAL_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [BIN_OUT_W-1:0] bin_index;
        logic [VAL_W-1:0]     maximum;
        logic                 day_out_of_range;
    } t_out_item;

    function automatic logic [DOY_W-1:0] month_end(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] e;
        case (m)
            4'd0:    e = 10'd31;
            4'd1:    e = 10'd59;
            4'd2:    e = 10'd90;
            4'd3:    e = 10'd120;
            4'd4:    e = 10'd151;
            4'd5:    e = 10'd181;
            4'd6:    e = 10'd213;
            4'd7:    e = 10'd244;
            4'd8:    e = 10'd274;
            4'd9:    e = 10'd304;
            4'd10:   e = 10'd334;
            default: e = 10'd365;
        endcase
        return e;
    endfunction

    function automatic logic [1:0] month_season(input logic [MONTH_W-1:0] m);
        logic [1:0] s;
        case (m)
            4'd2, 4'd3, 4'd4: s = 2'd1;
            4'd5, 4'd6, 4'd7: s = 2'd2;
            4'd8, 4'd9, 4'd10: s = 2'd3;
            default:          s = 2'd0;
        endcase
        return s;
    endfunction

    function automatic logic float_gt(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        logic g;
        if (a[30:0] > 31'h7F80_0000) begin
            g = 1'b0;
        end else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
            g = 1'b0;
        end else if (a[31] != b[31]) begin
            g = b[31];
        end else if (!a[31]) begin
            g = a[30:0] > b[30:0];
        end else begin
            g = a[30:0] < b[30:0];
        end
        return g;
    endfunction

endpackage

// ===== rtl/core/cbms_chan_if.sv =====
// Valid/ready channel carrying one item payload.
`timescale 1ns / 1ps
interface cbms_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/cbms_day_map.sv =====
// Day to aggregation bin mapping on a 365-day calendar.
`timescale 1ns / 1ps
module cbms_day_map (
    input  logic [1:0]                 i_mode,
    input  logic [cbms_pkg::DAY_W-1:0] i_day,
    input  logic [cbms_pkg::YEAR_W-1:0] i_year_est,
    output logic [cbms_pkg::BIN_W-1:0] o_bin
);
    import cbms_pkg::*;

    logic [DAY_W:0]      prod;
    logic [DAY_W:0]      diff;
    logic [YEAR_W-1:0]   year;
    logic [DOY_W-1:0]    doy;
    logic [MONTH_W-1:0]  month;

    always_comb begin
        prod = DAY_W'(i_year_est) * (DAY_W+1)'(DAYS_PER_YEAR);
        diff = {1'b0, i_day} - prod;
        if (diff >= (DAY_W+1)'(DAYS_PER_YEAR)) begin
            year = i_year_est + YEAR_W'(1);
            doy  = DOY_W'(diff - (DAY_W+1)'(DAYS_PER_YEAR));
        end else begin
            year = i_year_est;
            doy  = DOY_W'(diff);
        end
        month = '0;
        for (int i = 0; i < 11; i++) begin
            if (doy >= month_end(MONTH_W'(i))) begin
                month = month + MONTH_W'(1);
            end
        end
        case (i_mode)
            MODE_MONTHLY:  o_bin = BIN_W'(year) * BIN_W'(12) + BIN_W'(month);
            MODE_SEASONAL: o_bin = BIN_W'(year) * BIN_W'(4) + BIN_W'(month_season(month));
            default:       o_bin = BIN_W'(year);
        endcase
    end

endmodule

// ===== rtl/core/calendar_block_maxima_store.sv =====
// Top level of the calendar block-maxima store: sequencer, store memory, config.
//
//  channel   dir  payload                                   transfer
//  i_in      in   kind, day, location, sample               valid & ready
//  o_out     out  bin_index, maximum, day_out_of_range      valid & ready
//  i_cfg_*   in   index, data                               write enable high
//
// One item at a time: a new item is taken only once the previous one has passed
// year estimate, bin map, store read, compare and write back, and its result is
// registered for output. Input is taken only in the idle cycle.
// After reset a clearing pass writes -FLT_MAX to all MAX_YEARS*12*LOCATIONS
// store entries, one per cycle, with no input taken; config is taken.
// A result waiting in the output register holds only the final write back stage.
`timescale 1ns / 1ps
module calendar_block_maxima_store #(
    parameter int LOCATIONS = 256,
    parameter int MAX_YEARS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cbms_chan_if.sink                    i_in,
    cbms_chan_if.source                  o_out,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [3:0]                   i_cfg_data
);
    import cbms_pkg::*;

    localparam int DEPTH = MAX_YEARS * 12 * LOCATIONS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DIV, S_MAP, S_READ, S_UPDATE
    } t_state;

    t_state            r_state;
    t_cfg              r_cfg;
    t_in_item          r_item;
    logic [YEAR_W-1:0] r_year_est;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_clr_addr;
    logic [BIN_W-1:0]  r_bin;
    logic              r_oor;
    logic              r_loc_bad;
    logic [VAL_W-1:0]  r_rdata;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [VAL_W-1:0]  mem [DEPTH];

    logic [BIN_W-1:0]  map_bin;
    logic [6:0]        yrs;
    logic [LIM_W-1:0]  lim;
    logic [DAY_W+11:0] recip_prod;
    logic              upd_go;
    logic              upd_write;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [VAL_W-1:0]  mem_wd;

    cbms_day_map u_day_map (
        .i_mode     (r_cfg.aggregation_mode),
        .i_day      (r_item.day),
        .i_year_est (r_year_est),
        .o_bin      (map_bin)
    );

    always_comb begin
        recip_prod = (DAY_W+12)'(r_item.day) * (DAY_W+12)'(RECIP);
        yrs = (32'(r_cfg.years_in_use) > MAX_YEARS) ? 7'(MAX_YEARS) : 7'(r_cfg.years_in_use);
        lim = LIM_W'(yrs) * LIM_W'(DAYS_PER_YEAR);
        upd_go    = (r_state == S_UPDATE) && (!r_out_valid || o_out.ready);
        upd_write = upd_go && !r_oor && !r_loc_bad && (r_item.kind == KIND_UPDATE)
                    && float_gt(r_item.sample, r_rdata);
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = NEG_FLT_MAX;
        end else begin
            mem_we = upd_write;
            mem_wa = r_addr;
            mem_wd = r_item.sample;
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_cfg       <= '{aggregation_mode: MODE_ANNUAL, years_in_use: 4'd8};
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MODE:  r_cfg.aggregation_mode <= i_cfg_data[1:0];
                    CFG_YEARS: r_cfg.years_in_use     <= i_cfg_data;
                    default:   ;
                endcase
            end
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (32'(r_clr_addr) == DEPTH - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_item  <= i_in.data;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_year_est <= YEAR_W'(recip_prod >> RECIP_SHIFT);
                    r_state    <= S_MAP;
                end
                S_MAP: begin
                    r_bin     <= map_bin;
                    r_oor     <= {1'b0, r_item.day} >= lim;
                    r_loc_bad <= (32'(r_item.location) >= LOCATIONS)
                                 || (32'(map_bin) >= MAX_YEARS * 12);
                    r_addr    <= AW'(32'(map_bin) * LOCATIONS + 32'(r_item.location));
                    r_state   <= S_READ;
                end
                S_READ: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (upd_go) begin
                        r_out_valid <= 1'b1;
                        if (r_oor) begin
                            r_out <= '{bin_index: '0, maximum: '0, day_out_of_range: 1'b1};
                        end else if (r_loc_bad) begin
                            r_out <= '{bin_index: r_bin[BIN_OUT_W-1:0], maximum: NEG_FLT_MAX,
                                       day_out_of_range: 1'b0};
                        end else begin
                            r_out <= '{bin_index: r_bin[BIN_OUT_W-1:0],
                                       maximum: upd_write ? r_item.sample : r_rdata,
                                       day_out_of_range: 1'b0};
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the calendar block-maxima store: driver, monitor and predictor.
`timescale 1ns / 1ps
module tb_top;
    import cbms_pkg::*;

    localparam int NLOC      = 256;
    localparam int NYEARS    = 8;
    localparam int NRANDOM   = 1950;
    localparam int CLEAR_CYC = NYEARS * 12 * NLOC;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = CFG_MODE;
    logic [3:0] cfg_data = 4'd0;

    cbms_chan_if #(.T(t_in_item))  in_ch ();
    cbms_chan_if #(.T(t_out_item)) out_ch ();

    calendar_block_maxima_store #(.LOCATIONS(NLOC), .MAX_YEARS(NYEARS)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_in_item     pending_items[$];
    t_out_item    expected_maxima[$];
    logic [31:0]  max_model[NYEARS*12*NLOC];
    logic [1:0]   mode_model = MODE_ANNUAL;
    logic [3:0]   years_model = 4'd8;
    int           errors = 0;
    bit           quiet = 1'b0;
    bit           in_acc = 1'b0;
    int           in_gap = 0;
    int           out_gap = 0;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        foreach (max_model[k]) max_model[k] = NEG_FLT_MAX;
    end

    function automatic bit sample_gt(logic [31:0] a, logic [31:0] b);
        if (a[30:0] > 31'h7F80_0000) return 1'b0;
        if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
        if (a[31] != b[31]) return b[31];
        if (!a[31]) return a[30:0] > b[30:0];
        return a[30:0] < b[30:0];
    endfunction

    function automatic t_out_item predict_maximum(t_in_item it);
        t_out_item r;
        int unsigned yrs, yr, doy, mon, bin, addr;
        int unsigned ends[12] = '{31, 59, 90, 120, 151, 181, 213, 244, 274, 304, 334, 365};
        int unsigned seas[12] = '{0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3, 0};
        yrs = (years_model > NYEARS) ? NYEARS : years_model;
        r = '0;
        if (it.day >= yrs * 365) begin
            r.day_out_of_range = 1'b1;
            return r;
        end
        yr  = it.day / 365;
        doy = it.day % 365;
        mon = 11;
        for (int i = 11; i >= 0; i--) if (doy < ends[i]) mon = i;
        if (mode_model == MODE_MONTHLY) bin = yr * 12 + mon;
        else if (mode_model == MODE_SEASONAL) bin = yr * 4 + seas[mon];
        else bin = yr;
        r.bin_index = bin[6:0];
        addr = bin * NLOC + it.location;
        if (it.kind == KIND_UPDATE && sample_gt(it.sample, max_model[addr]))
            max_model[addr] = it.sample;
        r.maximum = max_model[addr];
        return r;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_acc) begin
        end else if (in_gap > 0) begin
            in_gap <= in_gap - 1;
            in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0 && (quiet || $urandom_range(0, 5) != 0)) begin
            in_ch.data  <= pending_items.pop_front();
            in_ch.valid <= 1'b1;
        end else begin
            in_ch.valid <= 1'b0;
            if (!quiet && pending_items.size() > 0) in_gap <= $urandom_range(1, 3);
        end
        if (!quiet && out_gap == 0 && $urandom_range(0, 5) == 0) begin
            out_gap <= $urandom_range(1, 4);
            out_ch.ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            out_ch.ready <= (out_gap == 1);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        in_acc <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready)
            expected_maxima.insert(expected_maxima.size(), predict_maximum(in_ch.data));
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_maxima.size() == 0) begin
                $display("%0t unexpected transfer: expected none actual %h", $time,
                         out_ch.data);
                errors++;
            end else begin
                exp_r = expected_maxima.pop_front();
                if (exp_r.bin_index != out_ch.data.bin_index) begin
                    $display("%0t bin_index expected %0d actual %0d", $time,
                             exp_r.bin_index, out_ch.data.bin_index);
                    errors++;
                end
                if (exp_r.maximum != out_ch.data.maximum) begin
                    $display("%0t maximum expected %h actual %h", $time,
                             exp_r.maximum, out_ch.data.maximum);
                    errors++;
                end
                if (exp_r.day_out_of_range != out_ch.data.day_out_of_range) begin
                    $display("%0t day_out_of_range expected %b actual %b", $time,
                             exp_r.day_out_of_range, out_ch.data.day_out_of_range);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic idx, logic [3:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MODE) mode_model = val[1:0];
        else years_model = val;
    endtask

    task automatic drain_results();
        while (pending_items.size() > 0 || in_ch.valid || expected_maxima.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic add_item(logic k, logic [13:0] d, logic [7:0] l, logic [31:0] s);
        t_in_item it;
        it.kind = k;
        it.day = d;
        it.location = l;
        it.sample = s;
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic logic [31:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 32'h7FC0_0001;
            1: return {$urandom_range(0, 1) == 1, 31'd0};
            2: return 32'h7F80_0000;
            3: return 32'hFF80_0000;
            4: return NEG_FLT_MAX;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n, int maxday);
        for (int i = 0; i < n; i++) begin
            add_item($urandom_range(0, 3) == 0,
                     14'((i % 9 == 0) ? $urandom_range(0, 16383) : $urandom_range(0, maxday)),
                     8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 3)),
                     random_sample());
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (CLEAR_CYC + 20) @(posedge i_clk);
        add_item(1'b1, 14'd0, 8'd0, 32'd0);
        add_item(1'b0, 14'd0, 8'd0, 32'h8000_0000);
        add_item(1'b0, 14'd0, 8'd0, 32'h0000_0000);
        add_item(1'b0, 14'd0, 8'd0, 32'h7FC0_0000);
        add_item(1'b0, 14'd0, 8'd0, 32'hFFFF_FFFF);
        add_item(1'b0, 14'd2919, 8'd255, 32'h7F80_0000);
        add_item(1'b0, 14'd2920, 8'd1, 32'h3F80_0000);
        add_item(1'b0, 14'd16383, 8'd255, 32'hFFFF_FFFF);
        drain_results();
        write_reg(CFG_MODE, {2'b00, MODE_MONTHLY});
        add_item(1'b0, 14'd30, 8'd2, 32'h4000_0000);
        add_item(1'b0, 14'd31, 8'd2, 32'h4000_0000);
        add_item(1'b0, 14'd364, 8'd2, 32'h4000_0000);
        add_item(1'b1, 14'd365, 8'd2, 32'h0);
        drain_results();
        write_reg(CFG_MODE, {2'b00, MODE_SEASONAL});
        add_item(1'b0, 14'd58, 8'd3, 32'h4040_0000);
        add_item(1'b0, 14'd59, 8'd3, 32'h4040_0000);
        add_item(1'b0, 14'd334, 8'd3, 32'h4040_0000);
        add_item(1'b1, 14'd2919, 8'd3, 32'h0);
        drain_results();
        write_reg(CFG_MODE, 4'd3);
        write_reg(CFG_YEARS, 4'd0);
        add_item(1'b0, 14'd0, 8'd0, 32'h3F80_0000);
        drain_results();
        write_reg(CFG_YEARS, 4'd15);
        add_item(1'b0, 14'd2919, 8'd4, 32'h3F80_0000);
        add_item(1'b0, 14'd2920, 8'd4, 32'h3F80_0000);
        drain_results();
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_MODE, 4'(p % 3));
            write_reg(CFG_YEARS, (p == 5) ? 4'd1 : 4'($urandom_range(1, 8)));
            random_phase(NRANDOM / 7, years_model * 365 - 1);
            drain_results();
        end
        quiet = 1'b1;
        write_reg(CFG_MODE, {2'b00, MODE_MONTHLY});
        write_reg(CFG_YEARS, 4'd8);
        random_phase(NRANDOM / 7, 2919);
        drain_results();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(4 * (CLEAR_CYC + 200000));
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
